/* design/mssseq_pkg.sv */
`default_nettype none

package mssseq_pkg;

    // tick width default for the top level
    localparam int TICK_WIDTH_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_READ_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_IVL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONV_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READY_MASK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OVERRUN_MASK = 3'd6;

    // event operations
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_DONE  = 3'd1;
    localparam logic [2:0] OP_ERROR = 3'd2;
    localparam logic [2:0] OP_TMO   = 3'd3;
    localparam logic [2:0] OP_ARM   = 3'd4;

    // bus commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_TRIGGER = 3'd1;
    localparam logic [2:0] CMD_STATUS  = 3'd2;
    localparam logic [2:0] CMD_AXIS    = 3'd3;
    localparam logic [2:0] CMD_ABORT   = 3'd4;

    // transfer phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_STAT = 2'd2;
    localparam logic [1:0] PH_AXIS = 2'd3;

    // failure stage codes
    localparam logic [3:0] STG_NONE        = 4'd0;
    localparam logic [3:0] STG_START_TRIG  = 4'd1;
    localparam logic [3:0] STG_START_STAT  = 4'd2;
    localparam logic [3:0] STG_START_AXIS  = 4'd3;
    localparam logic [3:0] STG_ERR_TRIG    = 4'd4;
    localparam logic [3:0] STG_ERR_STAT    = 4'd5;
    localparam logic [3:0] STG_ERR_AXIS    = 4'd6;
    localparam logic [3:0] STG_TMO_TRIG    = 4'd7;
    localparam logic [3:0] STG_TMO_STAT    = 4'd8;
    localparam logic [3:0] STG_TMO_AXIS    = 4'd9;
    localparam logic [3:0] STG_POST_SAMPLE = 4'd10;
    localparam logic [3:0] STG_CONVERSION  = 4'd11;
    localparam logic [3:0] STG_INVALID     = 4'd12;

    typedef struct packed {
        logic [7:0]  read_delay;
        logic [7:0]  poll_ivl;
        logic [7:0]  retry_delay;
        logic [15:0] conv_timeout;
        logic [7:0]  fail_limit;
        logic [7:0]  ready_mask;
        logic [7:0]  overrun_mask;
    } t_cfg;

    // event word without its time stamp
    typedef struct packed {
        logic [2:0] operation;
        logic       bus_ready;
        logic [7:0] status_byte;
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] z_low;
        logic [7:0] z_high;
    } t_event;

    typedef struct packed {
        logic [2:0]         command;
        logic               recover;
        logic               sample_valid;
        logic signed [15:0] body_x;
        logic signed [15:0] body_y;
        logic signed [15:0] body_z;
        logic               overrun_seen;
        logic [3:0]         failure_stage;
        logic [7:0]         failure_count;
    } t_result;

endpackage

`default_nettype wire

/* design/magnetometer_single_shot_sequencer_core.sv */
`default_nettype none

// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ------------------------------------
// event     in         i_in_valid / o_in_stall    i_operation, i_time_now, bus, bytes
// result    out        o_out_valid / i_out_stall  o_command ... o_failure_count
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one event word per cycle sustained while i_out_stall is low; an accepted event passes
// through the event register, then the result register
// each event produces exactly one result word
// synchronous active-low reset: sequencer halted until an armed event
// a stalled result holds; the event register takes one more word, then the event side stalls

module magnetometer_single_shot_sequencer_core #(
    parameter int TICK_WIDTH = mssseq_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // event channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_operation,
    input  wire logic [31:0]                       i_time_now,
    input  wire logic                              i_bus_ready,
    input  wire logic [7:0]                        i_status_byte,
    input  wire logic [7:0]                        i_x_low,
    input  wire logic [7:0]                        i_x_high,
    input  wire logic [7:0]                        i_y_low,
    input  wire logic [7:0]                        i_y_high,
    input  wire logic [7:0]                        i_z_low,
    input  wire logic [7:0]                        i_z_high,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [2:0]                             o_command,
    output logic                                   o_recover,
    output logic                                   o_sample_valid,
    output logic signed [15:0]                     o_body_x,
    output logic signed [15:0]                     o_body_y,
    output logic signed [15:0]                     o_body_z,
    output logic                                   o_overrun_seen,
    output logic [3:0]                             o_failure_stage,
    output logic [7:0]                             o_failure_count,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [mssseq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mssseq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mssseq_pkg::*;

    logic                  r_in_valid;
    logic                  n_in_valid;
    t_event                r_event;
    logic [TICK_WIDTH-1:0] r_time;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_result               r_out;
    t_result               result;
    t_cfg                  cfg;
    logic                  advance;
    logic                  accept;

    // handshake: event moves to result register when the result slot frees
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event.operation   <= i_operation;
            r_event.bus_ready   <= i_bus_ready;
            r_event.status_byte <= i_status_byte;
            r_event.x_low       <= i_x_low;
            r_event.x_high      <= i_x_high;
            r_event.y_low       <= i_y_low;
            r_event.y_high      <= i_y_high;
            r_event.z_low       <= i_z_low;
            r_event.z_high      <= i_z_high;
            r_time              <= TICK_WIDTH'(i_time_now);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    mssseq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mssseq_ctrl #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_event  (r_event),
        .i_time   (r_time),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_command       = r_out.command;
    assign o_recover       = r_out.recover;
    assign o_sample_valid  = r_out.sample_valid;
    assign o_body_x        = r_out.body_x;
    assign o_body_y        = r_out.body_y;
    assign o_body_z        = r_out.body_z;
    assign o_overrun_seen  = r_out.overrun_seen;
    assign o_failure_stage = r_out.failure_stage;
    assign o_failure_count = r_out.failure_count;

endmodule

`default_nettype wire

/* design/mssseq_cfg.sv */
`default_nettype none

module mssseq_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mssseq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mssseq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mssseq_pkg::t_cfg                      o_cfg
);
    import mssseq_pkg::*;

    t_cfg r_cfg;

    // register file with reset defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_delay   <= 8'd5;
            r_cfg.poll_ivl     <= 8'd1;
            r_cfg.retry_delay  <= 8'd1;
            r_cfg.conv_timeout <= 16'd20;
            r_cfg.fail_limit   <= 8'd3;
            r_cfg.ready_mask   <= 8'd1;
            r_cfg.overrun_mask <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_READ_DELAY:   r_cfg.read_delay   <= i_cfg_data[7:0];
                REG_POLL_IVL:     r_cfg.poll_ivl     <= i_cfg_data[7:0];
                REG_RETRY_DELAY:  r_cfg.retry_delay  <= i_cfg_data[7:0];
                REG_CONV_TIMEOUT: r_cfg.conv_timeout <= i_cfg_data[15:0];
                REG_FAIL_LIMIT:   r_cfg.fail_limit   <= i_cfg_data[7:0];
                REG_READY_MASK:   r_cfg.ready_mask   <= i_cfg_data[7:0];
                REG_OVERRUN_MASK: r_cfg.overrun_mask <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/mssseq_ctrl.sv */
`default_nettype none

module mssseq_ctrl #(
    parameter int TICK_WIDTH = mssseq_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire mssseq_pkg::t_event    i_event,
    input  wire logic [TICK_WIDTH-1:0] i_time,
    input  wire mssseq_pkg::t_cfg      i_cfg,
    output mssseq_pkg::t_result        o_result
);
    import mssseq_pkg::*;

    // sequencer state
    logic [1:0]            r_phase;
    logic                  r_awaiting;
    logic [TICK_WIDTH-1:0] r_meas_start;
    logic [TICK_WIDTH-1:0] r_next_action;
    logic [7:0]            r_failures;
    logic                  r_halted;

    logic [1:0]            n_phase;
    logic                  n_awaiting;
    logic [TICK_WIDTH-1:0] n_meas_start;
    logic [TICK_WIDTH-1:0] n_next_action;
    logic [7:0]            n_failures;
    logic                  n_halted;

    logic                  do_fail;
    logic [3:0]            fail_stage;
    logic [7:0]            fail_base;
    logic [7:0]            fail_count;
    logic [7:0]            fail_lim;
    logic [TICK_WIDTH-1:0] due_diff;
    logic                  due;
    logic [TICK_WIDTH-1:0] conv_diff;
    logic                  conv_expired;
    t_result               res;

    // deadline checks, wrap-aware on the top bit of the difference
    assign due_diff  = i_time - r_next_action;
    assign due       = !due_diff[TICK_WIDTH-1];
    assign conv_diff = i_time - (r_meas_start + TICK_WIDTH'(i_cfg.conv_timeout));
    assign conv_expired = !conv_diff[TICK_WIDTH-1];

    assign fail_lim = (i_cfg.fail_limit == 8'd0) ? 8'd1 : i_cfg.fail_limit;

    // event decode and next state
    always_comb begin
        n_phase       = r_phase;
        n_awaiting    = r_awaiting;
        n_meas_start  = r_meas_start;
        n_next_action = r_next_action;
        n_failures    = r_failures;
        n_halted      = r_halted;
        do_fail       = 1'b0;
        fail_stage    = STG_NONE;
        res           = '0;

        if (i_event.operation == OP_ARM) begin
            n_failures    = 8'd0;
            n_phase       = PH_IDLE;
            n_awaiting    = 1'b1;
            n_meas_start  = i_time;
            n_next_action = i_time + TICK_WIDTH'(i_cfg.read_delay);
            n_halted      = 1'b0;
        end else if (!r_halted) begin
            case (i_event.operation)
                OP_TICK: begin
                    if (r_phase == PH_IDLE && due) begin
                        if (!r_awaiting) begin
                            if (i_event.bus_ready) begin
                                n_phase     = PH_TRIG;
                                res.command = CMD_TRIGGER;
                            end else begin
                                do_fail    = 1'b1;
                                fail_stage = STG_START_TRIG;
                            end
                        end else if (i_event.bus_ready) begin
                            n_phase     = PH_STAT;
                            res.command = CMD_STATUS;
                        end else begin
                            n_awaiting = 1'b0;
                            do_fail    = 1'b1;
                            fail_stage = STG_START_STAT;
                        end
                    end
                end
                OP_DONE: begin
                    n_phase = PH_IDLE;
                    unique case (r_phase)
                        PH_TRIG: begin
                            n_meas_start  = i_time;
                            n_awaiting    = 1'b1;
                            n_next_action = i_time + TICK_WIDTH'(i_cfg.read_delay);
                        end
                        PH_STAT: begin
                            if ((i_event.status_byte & i_cfg.ready_mask) == 8'd0) begin
                                if (conv_expired) begin
                                    res.failure_stage = STG_CONVERSION;
                                    res.recover       = 1'b1;
                                    n_awaiting        = 1'b0;
                                    n_halted          = 1'b1;
                                end else begin
                                    n_next_action = i_time + TICK_WIDTH'(i_cfg.poll_ivl);
                                end
                            end else begin
                                res.overrun_seen =
                                    (i_event.status_byte & i_cfg.overrun_mask) != 8'd0;
                                if (i_event.bus_ready) begin
                                    n_phase     = PH_AXIS;
                                    res.command = CMD_AXIS;
                                end else begin
                                    n_awaiting = 1'b0;
                                    do_fail    = 1'b1;
                                    fail_stage = STG_START_AXIS;
                                end
                            end
                        end
                        PH_AXIS: begin
                            // sensor Y is body X, sensor X is body Y
                            n_awaiting       = 1'b0;
                            res.sample_valid = 1'b1;
                            res.body_x       = {i_event.y_high, i_event.y_low};
                            res.body_y       = {i_event.x_high, i_event.x_low};
                            res.body_z       = {i_event.z_high, i_event.z_low};
                            n_failures       = 8'd0;
                            if (i_event.bus_ready) begin
                                n_phase     = PH_TRIG;
                                res.command = CMD_TRIGGER;
                            end else begin
                                do_fail    = 1'b1;
                                fail_stage = STG_POST_SAMPLE;
                            end
                        end
                        default: begin
                            do_fail    = 1'b1;
                            fail_stage = STG_INVALID;
                        end
                    endcase
                end
                OP_ERROR, OP_TMO: begin
                    res.command = CMD_ABORT;
                    n_phase     = PH_IDLE;
                    n_awaiting  = 1'b0;
                    do_fail     = 1'b1;
                    unique case (r_phase)
                        PH_TRIG: fail_stage = (i_event.operation == OP_ERROR) ?
                                              STG_ERR_TRIG : STG_TMO_TRIG;
                        PH_STAT: fail_stage = (i_event.operation == OP_ERROR) ?
                                              STG_ERR_STAT : STG_TMO_STAT;
                        PH_AXIS: fail_stage = (i_event.operation == OP_ERROR) ?
                                              STG_ERR_AXIS : STG_TMO_AXIS;
                        default: fail_stage = STG_INVALID;
                    endcase
                end
                default: ;
            endcase
        end

        // common failure handling: count, back off, recover at the limit
        fail_base  = n_failures;
        fail_count = (fail_base == 8'hFF) ? fail_base : fail_base + 8'd1;
        if (do_fail) begin
            res.failure_stage = fail_stage;
            n_failures        = fail_count;
            n_next_action     = i_time + TICK_WIDTH'(i_cfg.retry_delay);
            if (fail_count >= fail_lim) begin
                res.recover = 1'b1;
                n_halted    = 1'b1;
                n_phase     = PH_IDLE;
                n_awaiting  = 1'b0;
            end
        end
        res.failure_count = n_failures;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_awaiting    <= 1'b0;
            r_meas_start  <= '0;
            r_next_action <= '0;
            r_failures    <= 8'd0;
            r_halted      <= 1'b1;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_awaiting    <= n_awaiting;
            r_meas_start  <= n_meas_start;
            r_next_action <= n_next_action;
            r_failures    <= n_failures;
            r_halted      <= n_halted;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire
